### rtl/caliper_frame_decoder_defines.svh
// ----------------------------------------------------------------------------
// caliper frame decoder assertion macros
// concurrent checks that compile away when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef CALIPER_FRAME_DECODER_DEFINES_SVH
`define CALIPER_FRAME_DECODER_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define CFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("caliper frame decoder check failed");

// next-cycle implication
`define CFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("caliper frame decoder check failed");

`else

`define CFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### rtl/cfd_pkg.sv
// ----------------------------------------------------------------------------
// cfd_pkg
// shared types and constants of the caliper frame decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfd_pkg;

    localparam int TIME_W   = 32;
    localparam int GAP_W    = 16;
    localparam int POS_W    = 5;
    localparam int FRAME_LEN = 24;
    localparam int MAG_BITS = 20;
    localparam int SIGN_POS = 21;
    localparam int UNIT_POS = 24;

    typedef logic [TIME_W-1:0]    time_t;
    typedef logic [GAP_W-1:0]     gap_t;
    typedef logic [POS_W-1:0]     pos_t;
    typedef logic [FRAME_LEN-1:0] frame_t;
    typedef logic [MAG_BITS-1:0]  mag_t;

    // bit position codes: idle waits for a gap, done waits for the next gap
    localparam pos_t POS_IDLE  = 5'd0;
    localparam pos_t POS_FIRST = 5'd1;
    localparam pos_t POS_LAST  = 5'd24;
    localparam pos_t POS_DONE  = 5'd25;

    localparam gap_t GAP_RESET = 16'd500;

    typedef struct packed {
        time_t edge_time_us;
        logic  data_bit;
    } edge_item_t;

    typedef struct packed {
        logic       valid;
        edge_item_t item;
    } stage_t;

    typedef struct packed {
        mag_t magnitude;
        logic negative;
        logic inch_units;
    } result_t;

endpackage

### rtl/cfd_if.sv
// ----------------------------------------------------------------------------
// cfd interfaces
// valid/ready channels for caliper edges, decoded readings and config writes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cfd_edge_if;
    logic                     valid;
    logic                     ready;
    logic [cfd_pkg::TIME_W-1:0] edge_time_us;
    logic                     data_bit;

    modport source (output valid, output edge_time_us, output data_bit, input ready);
    modport sink   (input valid, input edge_time_us, input data_bit, output ready);
endinterface

interface cfd_result_if;
    logic                       valid;
    logic                       ready;
    logic [cfd_pkg::MAG_BITS-1:0] magnitude;
    logic                       negative;
    logic                       inch_units;

    modport source (output valid, output magnitude, output negative, output inch_units,
                    input ready);
    modport sink   (input valid, input magnitude, input negative, input inch_units,
                    output ready);
endinterface

interface cfd_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [cfd_pkg::GAP_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/caliper_frame_decoder.sv
// ----------------------------------------------------------------------------
// caliper_frame_decoder
// decodes the 24-bit serial frame of a digital caliper into a reading
// ----------------------------------------------------------------------------
// caliper: one item per falling edge of the caliper clock, with its
//   microsecond timestamp and the sampled data level
// cfg: writes the gap threshold in microseconds; always ready
// reading: magnitude, sign and inch flag, one item per completed frame
// an edge more than the gap threshold after the previous one starts a frame;
//   the 24th bit of a frame produces the reading, later edges are dropped
//   until the next gap
// path: an edge passes the input register, then is decoded into the result
//   register that holds the reading
// throughput: one edge per cycle while no reading waits to be taken, set by the
//   combinational gap compare and bit capture on the frame state
// reset: gap threshold 500 us, previous edge time 0, decoder waits for a gap
// stall: the reading holds while not taken; one more edge is absorbed by the
//   input register, then caliper.ready drops until the reading is taken
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module caliper_frame_decoder (
    input  logic         clk,
    input  logic         rst_n,
    cfd_edge_if.sink     caliper,
    cfd_cfg_if.sink      cfg,
    cfd_result_if.source reading
);
    import cfd_pkg::*;

    stage_t stage;
    logic   advance;

    cfd_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .edges   (caliper),
        .advance (advance),
        .stage   (stage)
    );

    cfd_frame_core u_frame_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .stage   (stage),
        .advance (advance),
        .cfg     (cfg),
        .reading (reading)
    );

endmodule

### rtl/cfd_in_stage.sv
// ----------------------------------------------------------------------------
// cfd_in_stage
// input register for caliper edge items
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfd_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    cfd_edge_if.sink          edges,
    input  logic              advance,
    output cfd_pkg::stage_t   stage
);
    import cfd_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    edge_item_t item_reg;
    edge_item_t item_next;
    logic       load;

    assign edges.ready = !valid_reg || advance;
    assign load        = edges.valid && edges.ready;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (edges.ready)
        begin
            valid_next = edges.valid;
        end
        if (load)
        begin
            item_next.edge_time_us = edges.edge_time_us;
            item_next.data_bit     = edges.data_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

### rtl/cfd_frame_core.sv
// ----------------------------------------------------------------------------
// cfd_frame_core
// gap detection, bit capture and result register of the frame decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "caliper_frame_decoder_defines.svh"

module cfd_frame_core (
    input  logic              clk,
    input  logic              rst_n,
    input  cfd_pkg::stage_t   stage,
    output logic              advance,
    cfd_cfg_if.sink           cfg,
    cfd_result_if.source      reading
);
    import cfd_pkg::*;

    gap_t    gap_reg;
    gap_t    gap_next;
    time_t   last_time_reg;
    time_t   last_time_next;
    pos_t    pos_reg;
    pos_t    pos_next;
    frame_t  frame_reg;
    frame_t  frame_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_reg;
    result_t out_next;

    time_t   dt;
    logic    gap_seen;
    pos_t    pos_eff;
    pos_t    bit_idx;
    logic    capture;
    logic    emit;
    logic    fire;

    assign cfg.ready = 1'b1;

    // the result register frees up in the same cycle it is taken
    assign advance = !out_valid_reg || reading.ready;
    assign fire    = stage.valid && advance;

    always_comb
    begin
        dt       = stage.item.edge_time_us - last_time_reg;
        gap_seen = dt > {{(TIME_W-GAP_W){1'b0}}, gap_reg};
        pos_eff  = gap_seen ? POS_FIRST : pos_reg;
        capture  = (pos_eff >= POS_FIRST) && (pos_eff <= POS_LAST);
        bit_idx  = pos_eff - POS_FIRST;
        emit     = capture && (pos_eff == POS_LAST);

        frame_next = frame_reg;
        if (fire && capture)
        begin
            frame_next[bit_idx] = stage.item.data_bit;
        end

        last_time_next = last_time_reg;
        pos_next       = pos_reg;
        if (fire)
        begin
            last_time_next = stage.item.edge_time_us;
            pos_next       = capture ? pos_eff + POS_FIRST : pos_eff;
        end

        gap_next = cfg.valid ? cfg.data : gap_reg;

        out_next = out_reg;
        if (fire && emit)
        begin
            out_next.magnitude  = frame_next[MAG_BITS-1:0];
            out_next.negative   = frame_next[SIGN_POS-1];
            out_next.inch_units = frame_next[UNIT_POS-1];
        end

        if (fire && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (reading.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg       <= GAP_RESET;
            last_time_reg <= '0;
            pos_reg       <= POS_IDLE;
            frame_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            gap_reg       <= gap_next;
            last_time_reg <= last_time_next;
            pos_reg       <= pos_next;
            frame_reg     <= frame_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign reading.valid      = out_valid_reg;
    assign reading.magnitude  = out_reg.magnitude;
    assign reading.negative   = out_reg.negative;
    assign reading.inch_units = out_reg.inch_units;

    `CFD_ASSERT_NXT(a_emit_done, clk, rst_n, fire && emit, pos_reg == POS_DONE)
    `CFD_ASSERT_IMP(a_rise_from_emit, clk, rst_n, $rose(out_valid_reg), $past(fire && emit))
    `CFD_ASSERT_NXT(a_stall_holds, clk, rst_n, out_valid_reg && !reading.ready,
                    $stable(last_time_reg) && $stable(pos_reg) && $stable(frame_reg))
    `CFD_ASSERT_IMP(a_pos_range, clk, rst_n, 1'b1, pos_reg <= POS_DONE)

endmodule

### dv/tb_caliper_frame_decoder.sv
// ----------------------------------------------------------------------------
// tb_caliper_frame_decoder
// drives caliper edges with their timestamps into the frame decoder and checks
// every decoded reading against a cycle-free predictor of the frame logic;
// sender bursts and receiver stalls are random, gap threshold is swept
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_caliper_frame_decoder;
    import cfd_pkg::*;

    localparam int          DRAIN_CYCLES = 6;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_SPARSE,
        STALL_LONG
    } stall_mode_t;

    logic clk;
    logic rst_n;

    cfd_edge_if   caliper_if ();
    cfd_cfg_if    cfg_if ();
    cfd_result_if reading_if ();

    caliper_frame_decoder u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .caliper (caliper_if),
        .cfg     (cfg_if),
        .reading (reading_if)
    );

    // predictor state
    gap_t    gap_reg;
    time_t   last_edge;
    pos_t    bit_pos;
    frame_t  frame_bits;
    result_t expected_readings[$];
    int      readings_predicted;

    // stimulus state
    time_t       now_us;
    int          edges_sent;
    int          burst_left;
    int          fail_count;
    int unsigned cycle_count;
    stall_mode_t stall_mode;
    logic [5:0]  stall_tick;

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: stall pattern changes each time stall_tick wraps to zero
    initial reading_if.ready = 1'b0;

    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 6'd1;
        if (stall_tick == 6'd0)
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
        case (stall_mode)
            STALL_NONE:   reading_if.ready <= 1'b1;
            STALL_RANDOM: reading_if.ready <= 1'($urandom_range(0, 1));
            STALL_SPARSE: reading_if.ready <= (stall_tick[1:0] == 2'b11);
            default:      reading_if.ready <= (stall_tick[4:0] >= 5'd20);
        endcase
    end

    always @(posedge clk)
    begin
        result_t exp_rd;
        if (rst_n && reading_if.valid && reading_if.ready)
        begin
            if (expected_readings.size() == 0)
            begin
                $error("reading with none expected: magnitude %0h", reading_if.magnitude);
                fail_count++;
            end
            else
            begin
                exp_rd = expected_readings.pop_front();
                if (reading_if.magnitude !== exp_rd.magnitude)
                begin
                    $error("magnitude: expected %0h, got %0h",
                           exp_rd.magnitude, reading_if.magnitude);
                    fail_count++;
                end
                if (reading_if.negative !== exp_rd.negative)
                begin
                    $error("negative: expected %0b, got %0b",
                           exp_rd.negative, reading_if.negative);
                    fail_count++;
                end
                if (reading_if.inch_units !== exp_rd.inch_units)
                begin
                    $error("inch_units: expected %0b, got %0b",
                           exp_rd.inch_units, reading_if.inch_units);
                    fail_count++;
                end
            end
        end
    end

    task automatic decode_edge(input time_t t, input logic b);
        time_t   dt;
        result_t rd;
        dt        = t - last_edge;
        last_edge = t;
        if (dt > {16'd0, gap_reg})
            bit_pos = POS_FIRST;
        if (bit_pos >= POS_FIRST && bit_pos <= POS_LAST)
        begin
            frame_bits[bit_pos - POS_FIRST] = b;
            bit_pos = bit_pos + POS_FIRST;
            if (bit_pos == POS_DONE)
            begin
                rd.magnitude  = frame_bits[MAG_BITS-1:0];
                rd.negative   = frame_bits[SIGN_POS-1];
                rd.inch_units = frame_bits[UNIT_POS-1];
                expected_readings.push_back(rd);
                readings_predicted++;
            end
        end
    endtask

    task automatic send_edge(input time_t t, input logic b);
        int idle;
        caliper_if.valid        <= 1'b1;
        caliper_if.edge_time_us <= t;
        caliper_if.data_bit     <= b;
        do
            @(posedge clk);
        while (!caliper_if.ready);
        decode_edge(t, b);
        edges_sent++;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (idle != 0)
            begin
                caliper_if.valid <= 1'b0;
                repeat (idle) @(posedge clk);
            end
        end
        else
            burst_left--;
    endtask

    task automatic wait_idle();
        caliper_if.valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_gap(input gap_t v);
        wait_idle();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        gap_reg = v;
    endtask

    // spacing that opens a new frame
    function automatic time_t gap_dt();
        case ($urandom_range(0, 3))
            0:       return {16'd0, gap_reg} + 32'd1;
            1:       return 32'h0001_0000 | $urandom();
            default: return {16'd0, gap_reg} + 32'd1 + $urandom_range(0, 3000);
        endcase
    endfunction

    // spacing that stays inside a frame
    function automatic time_t bit_dt();
        if ($urandom_range(0, 3) == 0)
            return {16'd0, gap_reg};
        return $urandom_range(0, gap_reg);
    endfunction

    task automatic send_frame_bits(input frame_t bits, input int first, input int last);
        for (int i = first; i <= last; i++)
        begin
            now_us = now_us + bit_dt();
            send_edge(now_us, bits[i]);
        end
    endtask

    task automatic send_frame(input frame_t bits, input int n_bits);
        now_us = now_us + gap_dt();
        send_edge(now_us, bits[0]);
        send_frame_bits(bits, 1, n_bits - 1);
    endtask

    task automatic test_before_first_gap();
        // exactly the threshold is not a gap, nor is a repeated timestamp
        now_us = {16'd0, gap_reg};
        send_edge(now_us, 1'b1);
        send_edge(now_us, 1'b0);
    endtask

    task automatic test_wrapping_frame();
        now_us = 32'hFFFF_FFFF;
        send_edge(now_us, 1'b1);
        now_us = 32'h0000_0000;
        send_edge(now_us, 1'b1);
        send_frame_bits(24'hFF_FFFF, 2, FRAME_LEN - 1);
        // frame done, these are dropped
        send_frame_bits(24'h00_0000, 0, 1);
    endtask

    task automatic test_restart_mid_frame();
        send_frame(frame_t'($urandom()), 9);
        send_frame(24'h00_0000, FRAME_LEN);
        send_frame(24'h90_0001, FRAME_LEN);
        send_frame(24'h6F_FFFE, FRAME_LEN);
    endtask

    task automatic test_gap_extremes();
        write_gap(16'd0);
        send_frame(frame_t'($urandom()), FRAME_LEN);
        send_edge(now_us, 1'b1);
        write_gap(16'hFFFF);
        send_frame(frame_t'($urandom()), FRAME_LEN);
        write_gap(16'd1);
        send_frame(frame_t'($urandom()), FRAME_LEN);
    endtask

    task automatic run_traffic(input int n_edges, input int min_readings);
        int start;
        int pick;
        start = edges_sent;
        while (edges_sent - start < n_edges || readings_predicted < min_readings)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    now_us = ($urandom_range(0, 1) == 0) ? $urandom()
                                                         : now_us + $urandom_range(0, 700);
                    send_edge(now_us, 1'($urandom_range(0, 1)));
                end
            end
            else if (pick == 1)
                send_frame(frame_t'($urandom()), $urandom_range(1, FRAME_LEN - 1));
            else
            begin
                send_frame(frame_t'($urandom()), FRAME_LEN);
                send_frame_bits(frame_t'($urandom()), 0, $urandom_range(0, 3) - 1);
            end
        end
    endtask

    task automatic test_random_traffic();
        gap_t settings[5];
        settings = '{16'd1, 16'hFFFF, 16'd0, gap_t'($urandom()), GAP_RESET};
        foreach (settings[i])
        begin
            write_gap(settings[i]);
            now_us = $urandom();
            run_traffic(140, (i == 4) ? 48 : 0);
        end
    endtask

    initial
    begin
        rst_n                   <= 1'b0;
        caliper_if.valid        <= 1'b0;
        caliper_if.edge_time_us <= '0;
        caliper_if.data_bit     <= 1'b0;
        cfg_if.valid            <= 1'b0;
        cfg_if.data             <= '0;
        stall_mode              = STALL_NONE;
        stall_tick              = '0;
        cycle_count             = 0;
        gap_reg                 = GAP_RESET;
        last_edge               = '0;
        bit_pos                 = POS_IDLE;
        frame_bits              = '0;
        readings_predicted      = 0;
        edges_sent              = 0;
        burst_left              = 0;
        fail_count              = 0;
        now_us                  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_before_first_gap();
        test_wrapping_frame();
        test_restart_mid_frame();
        test_gap_extremes();
        test_random_traffic();

        wait_idle();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/cfd_pkg.sv
rtl/cfd_if.sv
rtl/cfd_in_stage.sv
rtl/cfd_frame_core.sv
rtl/caliper_frame_decoder.sv
dv/tb_caliper_frame_decoder.sv
